/* hdl/mlqs_pkg.sv */
// ----------------------------------------------------------------------------
// mlqs_pkg
// Types and codes shared by the multilevel queue scheduler files.
// ----------------------------------------------------------------------------
package mlqs_pkg;

    // Request codes
    localparam logic REQ_ADMIT    = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ADMITTED   = 2'd0;
    localparam logic [1:0] KIND_FULL       = 2'd1;
    localparam logic [1:0] KIND_DISPATCHED = 2'd2;
    localparam logic [1:0] KIND_IDLE_TICK  = 2'd3;

    // Band codes, lower code is served first
    localparam logic [1:0] BAND_HIGH = 2'd0;
    localparam logic [1:0] BAND_MED  = 2'd1;
    localparam logic [1:0] BAND_LOW  = 2'd2;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MED_THRESHOLD  = 1'd1;
    localparam logic [7:0] HIGH_THRESHOLD_RESET = 8'd10;
    localparam logic [7:0] MED_THRESHOLD_RESET  = 8'd5;

    typedef logic [31:0] time_t;
    typedef logic [1:0]  band_t;

    // One request item
    typedef struct packed {
        logic        req_type;
        logic [7:0]  job_id;
        logic [7:0]  job_priority;
        time_t       arrival_time;
        logic [15:0] burst_length;
    } req_item_t;

    // One result item
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] run_id;
        band_t      run_band;
        time_t      start_time;
        time_t      end_time;
        time_t      wait_time;
    } rsp_item_t;

    // One job table entry
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        time_t       arrival;
        logic [15:0] burst;
    } slot_t;

    // Best candidate seen so far in a dispatch scan
    typedef struct packed {
        logic       found;
        band_t      band;
        logic [7:0] prio;
    } best_t;

    // Verdict of the compare unit on one candidate
    typedef struct packed {
        logic  take;
        band_t band;
    } sel_t;

endpackage

/* hdl/mlqs_stream_if.sv */
// ----------------------------------------------------------------------------
// mlqs_stream_if
// Valid/ready channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface mlqs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/mlqs_ram.sv */
// ----------------------------------------------------------------------------
// mlqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/mlqs_sel.sv */
// ----------------------------------------------------------------------------
// mlqs_sel
// Compare unit: classifies one candidate slot into a band and decides
// whether it beats the best candidate found so far.
// ----------------------------------------------------------------------------
module mlqs_sel (
    input  logic            cand_valid,
    input  mlqs_pkg::slot_t cand,
    input  mlqs_pkg::time_t now,
    input  logic [7:0]      high_threshold,
    input  logic [7:0]      med_threshold,
    input  mlqs_pkg::best_t best,
    output mlqs_pkg::sel_t  verdict
);

    logic            eligible;
    mlqs_pkg::band_t band;

    // Classify by priority, high band tested first
    always_comb
    begin
        if (cand.prio > high_threshold)
        begin
            band = mlqs_pkg::BAND_HIGH;
        end
        else if (cand.prio > med_threshold)
        begin
            band = mlqs_pkg::BAND_MED;
        end
        else
        begin
            band = mlqs_pkg::BAND_LOW;
        end
    end

    // Only stored jobs that have arrived compete
    assign eligible = cand_valid && (cand.arrival <= now);

    // Strictly better wins, so ties keep the lower slot
    always_comb
    begin
        verdict.band = band;
        verdict.take = eligible &&
                       (!best.found || (band < best.band) ||
                        ((band == best.band) && (cand.prio < best.prio)));
    end

endmodule

/* hdl/multilevel_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler
// Non-preemptive three-level queue scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// Handles one request item at a time; request.ready is high only while the
// sequencer is idle. An admit walks the slot valid bits one per cycle to the
// lowest free slot. A dispatch streams every slot of the job table RAM
// through the single compare unit, one slot per cycle, and then updates the
// clock. The result sits in an output register, so the next request is taken
// while it waits. Thresholds are written through the cfg_we / cfg_index /
// cfg_data port; the user must write them only while no request is in
// progress, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mlqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlqs_pkg::CFG_DATA_W-1:0]    cfg_data,
    mlqs_stream_if.sink                        request,
    mlqs_stream_if.source                      result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADM   = 3'd1;
    localparam logic [2:0] ST_DSP   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_CALC  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [TABLE_DEPTH-1:0]    slot_valid_reg, slot_valid_next;
    logic [7:0]                high_thr_reg, med_thr_reg;
    mlqs_pkg::time_t           time_reg, time_next;
    mlqs_pkg::req_item_t       job_reg, job_next;
    mlqs_pkg::best_t           best_reg, best_next;
    mlqs_pkg::slot_t           best_slot_reg, best_slot_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    mlqs_pkg::rsp_item_t       res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    mlqs_pkg::rsp_item_t       out_data_reg, out_data_next;

    logic                      ram_we;
    mlqs_pkg::slot_t           ram_wdata;
    mlqs_pkg::slot_t           ram_rdata;
    mlqs_pkg::sel_t            verdict;
    logic                      out_load;
    logic [32:0]               end_sum;
    logic [32:0]               inc_sum;
    mlqs_pkg::time_t           end_sat;
    mlqs_pkg::time_t           inc_sat;

    // Job table
    assign ram_wdata = '{id:      job_reg.job_id,
                         prio:    job_reg.job_priority,
                         arrival: job_reg.arrival_time,
                         burst:   job_reg.burst_length};

    mlqs_ram #(
        .WIDTH ($bits(mlqs_pkg::slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Shared compare unit
    mlqs_sel u_sel (
        .cand_valid     (slot_valid_reg[rd_idx_reg]),
        .cand           (ram_rdata),
        .now            (time_reg),
        .high_threshold (high_thr_reg),
        .med_threshold  (med_thr_reg),
        .best           (best_reg),
        .verdict        (verdict)
    );

    // Saturating clock arithmetic
    assign end_sum = {1'b0, time_reg} + 33'(best_slot_reg.burst);
    assign inc_sum = {1'b0, time_reg} + 33'd1;
    assign end_sat = end_sum[32] ? '1 : end_sum[31:0];
    assign inc_sat = inc_sum[32] ? '1 : inc_sum[31:0];

    assign request.ready = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;
        slot_valid_next = slot_valid_reg;
        time_next       = time_reg;
        job_next        = job_reg;
        best_next       = best_reg;
        best_slot_next  = best_slot_reg;
        best_idx_next   = best_idx_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;

        // Fold in the slot read last cycle
        if (pend_reg && verdict.take)
        begin
            best_next.found = 1'b1;
            best_next.band  = verdict.band;
            best_next.prio  = ram_rdata.prio;
            best_slot_next  = ram_rdata;
            best_idx_next   = rd_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    job_next       = request.data;
                    idx_next       = '0;
                    best_next      = '0;
                    if (request.data.req_type == mlqs_pkg::REQ_ADMIT)
                    begin
                        state_next = ST_ADM;
                    end
                    else
                    begin
                        state_next = ST_DSP;
                    end
                end
            end
            ST_ADM:
            begin
                res_next = '0;
                if (!slot_valid_reg[idx_reg])
                begin
                    ram_we                   = 1'b1;
                    slot_valid_next[idx_reg] = 1'b1;
                    res_next.result_kind     = mlqs_pkg::KIND_ADMITTED;
                    state_next               = ST_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_next.result_kind = mlqs_pkg::KIND_FULL;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DSP:
            begin
                // Issue one table read per cycle
                pend_next   = 1'b1;
                rd_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                res_next            = '0;
                res_next.start_time = time_reg;
                if (best_reg.found)
                begin
                    res_next.result_kind        = mlqs_pkg::KIND_DISPATCHED;
                    res_next.run_id             = best_slot_reg.id;
                    res_next.run_band           = best_reg.band;
                    res_next.end_time           = end_sat;
                    res_next.wait_time          = time_reg - best_slot_reg.arrival;
                    slot_valid_next[best_idx_reg] = 1'b0;
                    time_next = (best_slot_reg.burst == '0) ? inc_sat : end_sat;
                end
                else
                begin
                    res_next.result_kind = mlqs_pkg::KIND_IDLE_TICK;
                    res_next.end_time    = inc_sat;
                    time_next            = inc_sat;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            slot_valid_reg <= '0;
            time_reg       <= '0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            rd_idx_reg     <= rd_idx_next;
            slot_valid_reg <= slot_valid_next;
            time_reg       <= time_next;
            best_reg       <= best_next;
            best_idx_reg   <= best_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        best_slot_reg <= best_slot_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= mlqs_pkg::HIGH_THRESHOLD_RESET;
            med_thr_reg  <= mlqs_pkg::MED_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mlqs_pkg::REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                mlqs_pkg::REG_MED_THRESHOLD:  med_thr_reg  <= cfg_data;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // Clock never runs backward
    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> time_reg >= $past(time_reg))
        else $error("scheduler clock decreased");

    // Table reads are in flight only during a dispatch scan
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_DSP || state_reg == ST_DRAIN))
        else $error("table read outside dispatch scan");

    // A dispatched job leaves the table
    a_dispatch_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC && best_reg.found) |=>
        !slot_valid_reg[$past(best_idx_reg)])
        else $error("dispatched slot still valid");

    // Emitted dispatch or idle tick never ends before it starts
    a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_reg.result_kind == mlqs_pkg::KIND_DISPATCHED ||
                      res_reg.result_kind == mlqs_pkg::KIND_IDLE_TICK)) |->
        res_reg.end_time >= res_reg.start_time)
        else $error("end time before start time");
`endif

endmodule
